// ===== rtl/psrp_pkg.sv =====
// Shared types and constants for the process scheduler.
package psrp_pkg;

    localparam int unsigned TW  = 24;
    localparam int unsigned AW  = 16;
    localparam int unsigned PW  = 8;
    localparam int unsigned IDW = 7;

    localparam logic [1:0] ST_WAIT  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [1:0] RK_ADDED  = 2'd0;
    localparam logic [1:0] RK_REJECT = 2'd1;
    localparam logic [1:0] RK_SCHED  = 2'd2;
    localparam logic [1:0] RK_NONE   = 2'd3;

    localparam logic REQ_ADD   = 1'b0;
    localparam logic REQ_SCHED = 1'b1;

    localparam logic       MODE_RR     = 1'b0;
    localparam logic [2:0] ADDR_MODE   = 3'd0;
    localparam logic [2:0] ADDR_SLICE  = 3'd4;
    localparam logic [15:0] SLICE_RST  = 16'd2;

    typedef enum logic [1:0] {
        SCAN_MARK,
        SCAN_EARLY,
        SCAN_PRIO
    } scan_kind_t;

    typedef struct packed {
        logic [AW-1:0] arrival;
        logic [AW-1:0] duration;
        logic [PW-1:0] prio;
        logic [AW-1:0] remaining;
        logic [TW-1:0] first_start;
        logic [1:0]    status;
    } entry_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_M1S,
        S_M1,
        S_ES,
        S_E,
        S_M2S,
        S_M2,
        S_PS,
        S_P,
        S_POP,
        S_POPW,
        S_FETCH,
        S_LOAD,
        S_RUN,
        S_NONE
    } state_t;

    typedef struct packed {
        logic       capture;
        logic       do_add;
        logic       scan_start;
        scan_kind_t scan_kind;
        logic       push_en;
        logic       jump;
        logic       pop;
        logic       fetch_best;
        logic       run;
        logic       res_none;
    } cmd_t;

    typedef struct packed {
        logic rr;
        logic scan_done;
        logic found;
        logic ring_empty;
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/process_scheduler_rr_prio.sv =====
// Top level of the round-robin / priority process scheduler.
//
// Input channel (in_valid/in_ready) carries one request per transfer: an add
// (arrive_time, run_duration, prio_level) or a schedule step. Each request
// yields exactly one result transfer on the output channel (out_valid/out_ready).
// A schedule step scans the process table with a pipelined pass of one entry
// per cycle through the table's single read port: one pass over the added
// processes, plus a priority pass in priority mode; when time must jump to the
// next arrival, an earliest-arrival pass, and in round robin a second marking
// pass after it; at most three passes.
// The result sits in an output register; a new request is taken while it
// waits, and work stalls only when a further result is ready before the
// receiver has taken the previous one.
// Reset clears the process count, time, ring pointers and the output valid;
// table contents are left as they are. Configuration (sched_mode at 0, time_slice at
// 2) must be written over the APB port while the block is idle; it does not enforce this.
module process_scheduler_rr_prio
#(
    parameter int MAX_PROCS   = 128,
    parameter int QUEUE_DEPTH = 128
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] arrive_time,
    input  logic [15:0] run_duration,
    input  logic [7:0]  prio_level,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  result_kind,
    output logic [6:0]  proc_id,
    output logic [23:0] slice_start,
    output logic [15:0] slice_len,
    output logic [15:0] time_left,
    output logic        finished,
    output logic [23:0] wait_time,
    output logic [23:0] turnaround,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    psrp_pkg::cmd_t  cmd;
    psrp_pkg::stat_t stat;

    logic        mode_reg;
    logic [15:0] slice_reg;
    logic        wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= psrp_pkg::MODE_RR;
            slice_reg <= psrp_pkg::SLICE_RST;
        end
        else if (wr_en)
        begin
            if (paddr == psrp_pkg::ADDR_MODE)
            begin
                mode_reg <= pwdata[0];
            end
            if (paddr == psrp_pkg::ADDR_SLICE)
            begin
                slice_reg <= pwdata[15:0];
            end
        end
    end

    always_comb
    begin
        unique case (paddr)
            psrp_pkg::ADDR_MODE:  prdata = {31'd0, mode_reg};
            psrp_pkg::ADDR_SLICE: prdata = {16'd0, slice_reg};
            default:              prdata = '0;
        endcase
    end

    psrp_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    psrp_dpath
    #(
        .MAX_PROCS   (MAX_PROCS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .sched_mode   (mode_reg),
        .time_slice   (slice_reg),
        .arrive_time  (arrive_time),
        .run_duration (run_duration),
        .prio_level   (prio_level),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_kind  (result_kind),
        .proc_id      (proc_id),
        .slice_start  (slice_start),
        .slice_len    (slice_len),
        .time_left    (time_left),
        .finished     (finished),
        .wait_time    (wait_time),
        .turnaround   (turnaround)
    );

endmodule

// ===== rtl/psrp_ctrl.sv =====
// Controller state machine sequencing add and schedule requests.
module psrp_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              req_type,
    output logic              in_ready,
    input  psrp_pkg::stat_t   stat,
    output psrp_pkg::cmd_t    cmd
);

    psrp_pkg::state_t state_reg;
    psrp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= psrp_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psrp_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = (req_type == psrp_pkg::REQ_SCHED) ? psrp_pkg::S_M1S
                                                                   : psrp_pkg::S_ADD;
                end
            end
            psrp_pkg::S_ADD:
            begin
                if (stat.out_free)
                begin
                    state_next = psrp_pkg::S_IDLE;
                end
            end
            psrp_pkg::S_M1S:
            begin
                state_next = psrp_pkg::S_M1;
            end
            psrp_pkg::S_M1:
            begin
                if (stat.scan_done)
                begin
                    if (!stat.rr)
                    begin
                        state_next = psrp_pkg::S_PS;
                    end
                    else if (stat.ring_empty)
                    begin
                        state_next = psrp_pkg::S_ES;
                    end
                    else
                    begin
                        state_next = psrp_pkg::S_POP;
                    end
                end
            end
            psrp_pkg::S_ES:
            begin
                state_next = psrp_pkg::S_E;
            end
            psrp_pkg::S_E:
            begin
                if (stat.scan_done)
                begin
                    if (!stat.found)
                    begin
                        state_next = psrp_pkg::S_NONE;
                    end
                    else
                    begin
                        state_next = stat.rr ? psrp_pkg::S_M2S : psrp_pkg::S_FETCH;
                    end
                end
            end
            psrp_pkg::S_M2S:
            begin
                state_next = psrp_pkg::S_M2;
            end
            psrp_pkg::S_M2:
            begin
                if (stat.scan_done)
                begin
                    state_next = stat.ring_empty ? psrp_pkg::S_NONE : psrp_pkg::S_POP;
                end
            end
            psrp_pkg::S_PS:
            begin
                state_next = psrp_pkg::S_P;
            end
            psrp_pkg::S_P:
            begin
                if (stat.scan_done)
                begin
                    state_next = stat.found ? psrp_pkg::S_FETCH : psrp_pkg::S_ES;
                end
            end
            psrp_pkg::S_POP:
            begin
                state_next = psrp_pkg::S_POPW;
            end
            psrp_pkg::S_POPW:
            begin
                state_next = psrp_pkg::S_LOAD;
            end
            psrp_pkg::S_FETCH:
            begin
                state_next = psrp_pkg::S_LOAD;
            end
            psrp_pkg::S_LOAD:
            begin
                state_next = psrp_pkg::S_RUN;
            end
            psrp_pkg::S_RUN:
            begin
                if (stat.out_free)
                begin
                    state_next = psrp_pkg::S_IDLE;
                end
            end
            psrp_pkg::S_NONE:
            begin
                if (stat.out_free)
                begin
                    state_next = psrp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = psrp_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            psrp_pkg::S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            psrp_pkg::S_ADD:
            begin
                cmd.do_add = stat.out_free;
            end
            psrp_pkg::S_M1S:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_kind  = psrp_pkg::SCAN_MARK;
                cmd.push_en    = stat.rr;
            end
            psrp_pkg::S_ES:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_kind  = psrp_pkg::SCAN_EARLY;
            end
            psrp_pkg::S_E:
            begin
                cmd.jump = stat.scan_done && stat.found;
            end
            psrp_pkg::S_M2S:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_kind  = psrp_pkg::SCAN_MARK;
                cmd.push_en    = 1'b1;
            end
            psrp_pkg::S_PS:
            begin
                cmd.scan_start = 1'b1;
                cmd.scan_kind  = psrp_pkg::SCAN_PRIO;
            end
            psrp_pkg::S_POPW:
            begin
                cmd.pop = 1'b1;
            end
            psrp_pkg::S_FETCH:
            begin
                cmd.fetch_best = 1'b1;
            end
            psrp_pkg::S_RUN:
            begin
                cmd.run = stat.out_free;
            end
            psrp_pkg::S_NONE:
            begin
                cmd.res_none = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

// ===== rtl/psrp_dpath.sv =====
// Datapath: process table, ready ring, scan engine, slice arithmetic, result register.
module psrp_dpath
#(
    parameter int MAX_PROCS   = 128,
    parameter int QUEUE_DEPTH = 128
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  psrp_pkg::cmd_t    cmd,
    output psrp_pkg::stat_t   stat,
    input  logic              sched_mode,
    input  logic [15:0]       time_slice,
    input  logic [15:0]       arrive_time,
    input  logic [15:0]       run_duration,
    input  logic [7:0]        prio_level,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        result_kind,
    output logic [6:0]        proc_id,
    output logic [23:0]       slice_start,
    output logic [15:0]       slice_len,
    output logic [15:0]       time_left,
    output logic              finished,
    output logic [23:0]       wait_time,
    output logic [23:0]       turnaround
);

    localparam int IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CW  = $clog2(MAX_PROCS + 1);
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int FW  = $clog2(QUEUE_DEPTH + 1);
    localparam int IDW = psrp_pkg::IDW;
    localparam int TW  = psrp_pkg::TW;

    psrp_pkg::entry_t mem [MAX_PROCS];
    logic [IW-1:0]    ring [QUEUE_DEPTH];

    psrp_pkg::entry_t rdata_reg;
    logic [IW-1:0]    ring_rd_reg;

    logic [CW-1:0]    count_reg, count_next;
    logic [TW-1:0]    now_reg, now_next;
    logic [QW-1:0]    head_reg, head_next;
    logic [QW-1:0]    tail_reg, tail_next;
    logic [FW-1:0]    fill_reg, fill_next;
    logic [CW-1:0]    issue_reg, issue_next;
    logic             pvld_reg, pvld_next;
    logic [IW-1:0]    pidx_reg, pidx_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             found_reg, found_next;
    logic [IW-1:0]    best_reg, best_next;
    logic [15:0]      bkey_reg, bkey_next;
    psrp_pkg::scan_kind_t kind_reg, kind_next;
    logic             push_reg, push_next;
    logic [IW-1:0]    cur_reg, cur_next;

    logic [15:0]      arr_reg, dur_reg;
    logic [7:0]       pri_reg;

    logic             ov_reg, ov_next;
    logic [1:0]       rk_reg;
    logic [IDW-1:0]   id_reg;
    logic [TW-1:0]    start_reg, wait_reg, turn_reg;
    logic [15:0]      len_reg, left_reg;
    logic             fin_reg;

    logic             issuing;
    logic             hit;
    logic             mark_hit;
    logic             we;
    logic [IW-1:0]    waddr;
    psrp_pkg::entry_t wdata;
    logic [IW-1:0]    raddr;
    logic             ring_we;
    logic [IW-1:0]    ring_wdata;
    logic             push_req;
    logic             out_free;
    logic             load;
    logic             rr;
    logic             can_add;

    logic [15:0]      ts;
    logic [15:0]      rlen;
    logic [15:0]      newrem;
    logic [TW-1:0]    first_val;
    logic [TW-1:0]    end_time;
    logic [TW-1:0]    arr_ext;
    logic             fin;
    logic [IW+IDW-1:0] add_id_ext;
    logic [IW+IDW-1:0] cur_id_ext;

    assign rr       = (sched_mode == psrp_pkg::MODE_RR);
    assign out_free = !ov_reg || out_ready;
    assign can_add  = (count_reg < CW'(MAX_PROCS));

    assign issuing  = busy_reg && (issue_reg < count_reg);
    assign raddr    = busy_reg ? issue_reg[IW-1:0] : cur_reg;

    assign arr_ext  = {{(TW-16){1'b0}}, rdata_reg.arrival};

    always_comb
    begin
        case (kind_reg)
            psrp_pkg::SCAN_MARK:
                hit = (rdata_reg.status == psrp_pkg::ST_WAIT) && (arr_ext <= now_reg);
            psrp_pkg::SCAN_EARLY:
                hit = (rdata_reg.status != psrp_pkg::ST_DONE) &&
                      (!found_reg || (rdata_reg.arrival < bkey_reg));
            psrp_pkg::SCAN_PRIO:
                hit = (rdata_reg.status == psrp_pkg::ST_READY) &&
                      (!found_reg || ({8'd0, rdata_reg.prio} < bkey_reg));
            default:
                hit = 1'b0;
        endcase
    end

    assign mark_hit = pvld_reg && hit && (kind_reg == psrp_pkg::SCAN_MARK);

    // slice arithmetic
    assign ts        = (time_slice == 16'd0) ? 16'd1 : time_slice;
    assign rlen      = (rr && (ts < rdata_reg.remaining)) ? ts : rdata_reg.remaining;
    assign newrem    = rdata_reg.remaining - rlen;
    assign fin       = (newrem == 16'd0);
    assign first_val = (rdata_reg.remaining == rdata_reg.duration) ? now_reg
                                                                   : rdata_reg.first_start;
    assign end_time  = now_reg + {{(TW-16){1'b0}}, rlen};

    assign add_id_ext = {{IDW{1'b0}}, count_reg[IW-1:0]};
    assign cur_id_ext = {{IDW{1'b0}}, cur_reg};

    assign push_req = (mark_hit && push_reg) || (cmd.run && rr && !fin);
    assign ring_we  = push_req && (fill_reg < FW'(QUEUE_DEPTH));
    assign ring_wdata = cmd.run ? cur_reg : pidx_reg;

    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg;
        wdata = rdata_reg;
        if (cmd.do_add && can_add)
        begin
            we                = 1'b1;
            waddr             = count_reg[IW-1:0];
            wdata.arrival     = arr_reg;
            wdata.duration    = dur_reg;
            wdata.prio        = pri_reg;
            wdata.remaining   = dur_reg;
            wdata.first_start = '0;
            wdata.status      = psrp_pkg::ST_WAIT;
        end
        else if (mark_hit)
        begin
            we           = 1'b1;
            waddr        = pidx_reg;
            wdata.status = psrp_pkg::ST_READY;
        end
        else if (cmd.run)
        begin
            we                = 1'b1;
            waddr             = cur_reg;
            wdata.remaining   = newrem;
            wdata.first_start = first_val;
            wdata.status      = fin ? psrp_pkg::ST_DONE : rdata_reg.status;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ring_we)
        begin
            ring[tail_reg] <= ring_wdata;
        end
        ring_rd_reg <= ring[head_reg];
    end

    always_comb
    begin
        count_next = count_reg;
        now_next   = now_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        fill_next  = fill_reg;
        issue_next = issue_reg;
        pvld_next  = issuing;
        pidx_next  = issue_reg[IW-1:0];
        busy_next  = busy_reg;
        done_next  = done_reg;
        found_next = found_reg;
        best_next  = best_reg;
        bkey_next  = bkey_reg;
        kind_next  = kind_reg;
        push_next  = push_reg;
        cur_next   = cur_reg;

        if (cmd.scan_start)
        begin
            issue_next = '0;
            pvld_next  = 1'b0;
            busy_next  = 1'b1;
            done_next  = 1'b0;
            found_next = 1'b0;
            kind_next  = cmd.scan_kind;
            push_next  = cmd.push_en;
        end
        else if (busy_reg)
        begin
            if (issuing)
            begin
                issue_next = issue_reg + 1'b1;
            end
            if (pvld_reg && hit && (kind_reg != psrp_pkg::SCAN_MARK))
            begin
                found_next = 1'b1;
                best_next  = pidx_reg;
                bkey_next  = (kind_reg == psrp_pkg::SCAN_EARLY) ? rdata_reg.arrival
                                                               : {8'd0, rdata_reg.prio};
            end
            if (!issuing && !pvld_reg)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        if (cmd.do_add && can_add)
        begin
            count_next = count_reg + 1'b1;
        end

        if (cmd.jump)
        begin
            now_next = {{(TW-16){1'b0}}, bkey_reg};
        end

        if (cmd.pop)
        begin
            cur_next  = ring_rd_reg;
            head_next = (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            fill_next = fill_reg - 1'b1;
        end

        if (cmd.fetch_best)
        begin
            cur_next = best_reg;
        end

        if (cmd.run)
        begin
            now_next = end_time;
        end

        if (ring_we)
        begin
            tail_next = (tail_reg == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            fill_next = fill_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            now_reg   <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
            issue_reg <= '0;
            pvld_reg  <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            found_reg <= 1'b0;
            kind_reg  <= psrp_pkg::SCAN_MARK;
            push_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            now_reg   <= now_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
            issue_reg <= issue_next;
            pvld_reg  <= pvld_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            found_reg <= found_next;
            kind_reg  <= kind_next;
            push_reg  <= push_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= pidx_next;
        best_reg <= best_next;
        bkey_reg <= bkey_next;
        cur_reg  <= cur_next;
        if (cmd.capture)
        begin
            arr_reg <= arrive_time;
            dur_reg <= run_duration;
            pri_reg <= prio_level;
        end
    end

    // result register
    assign load = cmd.do_add || cmd.res_none || cmd.run;

    always_comb
    begin
        ov_next = ov_reg;
        if (load)
        begin
            ov_next = 1'b1;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rk_reg    <= psrp_pkg::RK_NONE;
            id_reg    <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            left_reg  <= '0;
            fin_reg   <= 1'b0;
            wait_reg  <= '0;
            turn_reg  <= '0;
            if (cmd.do_add)
            begin
                rk_reg <= can_add ? psrp_pkg::RK_ADDED : psrp_pkg::RK_REJECT;
                id_reg <= can_add ? add_id_ext[IDW-1:0] : '0;
            end
            else if (cmd.run)
            begin
                rk_reg    <= psrp_pkg::RK_SCHED;
                id_reg    <= cur_id_ext[IDW-1:0];
                start_reg <= now_reg;
                len_reg   <= rlen;
                left_reg  <= newrem;
                fin_reg   <= fin;
                wait_reg  <= fin ? first_val - arr_ext : '0;
                turn_reg  <= fin ? end_time - arr_ext : '0;
            end
        end
    end

    assign out_valid   = ov_reg;
    assign result_kind = rk_reg;
    assign proc_id     = id_reg;
    assign slice_start = start_reg;
    assign slice_len   = len_reg;
    assign time_left   = left_reg;
    assign finished    = fin_reg;
    assign wait_time   = wait_reg;
    assign turnaround  = turn_reg;

    assign stat.rr         = rr;
    assign stat.scan_done  = done_reg;
    assign stat.found      = found_reg;
    assign stat.ring_empty = (fill_reg == '0);
    assign stat.out_free   = out_free;

endmodule

// ===== rtl/psrp_chk.sv =====
// Port-level checker for the process scheduler, bound to the top level.
module psrp_chk
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  result_kind,
    input logic [6:0]  proc_id,
    input logic [15:0] slice_len,
    input logic [15:0] time_left,
    input logic        finished
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(result_kind) && $stable(proc_id))
        else $error("result changed while stalled");

    a_fin_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == psrp_pkg::RK_SCHED) && finished |-> time_left == 16'd0)
        else $error("finished slice with time left");

    a_unfin_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind == psrp_pkg::RK_SCHED) && !finished
        |-> (time_left != 16'd0) && (slice_len != 16'd0))
        else $error("unfinished slice made no progress");

    a_nonsched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (result_kind != psrp_pkg::RK_SCHED) |-> (slice_len == 16'd0) && !finished)
        else $error("slice fields set on non-schedule result");

endmodule

bind process_scheduler_rr_prio psrp_chk u_psrp_chk
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result_kind (result_kind),
    .proc_id     (proc_id),
    .slice_len   (slice_len),
    .time_left   (time_left),
    .finished    (finished)
);

// ===== tb/sv/testbench.sv =====
// Testbench for the round-robin / priority process scheduler.
`timescale 1ns / 1ps

module testbench;

    localparam int NPROC = 128;
    localparam int NRING = 128;
    localparam int DRAIN = 700;
    localparam longint LIMIT = 2000000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [6:0]  id;
        logic [23:0] start;
        logic [15:0] len;
        logic [15:0] left;
        logic        fin;
        logic [23:0] wt;
        logic [23:0] ta;
    } sched_res_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        req_type;
    logic [15:0] arrive_time;
    logic [15:0] run_duration;
    logic [7:0]  prio_level;
    logic        out_valid;
    logic        out_ready;
    logic [1:0]  result_kind;
    logic [6:0]  proc_id;
    logic [23:0] slice_start;
    logic [15:0] slice_len;
    logic [15:0] time_left;
    logic        finished;
    logic [23:0] wait_time;
    logic [23:0] turnaround;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    process_scheduler_rr_prio i_dut (.*);

    // scheduler shadow state
    logic [15:0] arr_tab [NPROC];
    logic [15:0] dur_tab [NPROC];
    logic [15:0] rem_tab [NPROC];
    logic [7:0]  pri_tab [NPROC];
    logic [23:0] fst_tab [NPROC];
    logic [1:0]  st_tab  [NPROC];
    logic [6:0]  ring    [NRING];
    int          n_procs;
    int          ring_rd;
    int          ring_wr;
    int          ring_cnt;
    logic [23:0] now_t;
    logic        cfg_mode;
    logic [15:0] cfg_slice;

    sched_res_t  pending_res[$];
    int          n_err;
    longint      n_cycles;
    int          send_idle_pct;
    int          stall_pct;
    int          hold_req;
    int          hold_cnt;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles > LIMIT)
        begin
            $display("%0t timeout", $time);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        if (hold_req != 0)
        begin
            hold_cnt = hold_req;
            hold_req = 0;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge clk)
    begin
        sched_res_t got;
        sched_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {result_kind, proc_id, slice_start, slice_len, time_left,
                   finished, wait_time, turnaround};
            if (pending_res.size() == 0)
            begin
                n_err++;
                $display("%0t unexpected transfer: %p", $time, got);
            end
            else
            begin
                want = pending_res.pop_front();
                if (got !== want)
                begin
                    n_err++;
                    $display("%0t mismatch: expected %p actual %p", $time, want, got);
                end
            end
        end
    end

    function automatic void mark_arrived(bit to_ring);
        for (int i = 0; i < n_procs; i++)
            if (st_tab[i] == psrp_pkg::ST_WAIT && {8'd0, arr_tab[i]} <= now_t)
            begin
                st_tab[i] = psrp_pkg::ST_READY;
                if (to_ring && ring_cnt < NRING)
                begin
                    ring[ring_wr] = 7'(i);
                    ring_wr = (ring_wr + 1) % NRING;
                    ring_cnt++;
                end
            end
    endfunction

    function automatic bit find_earliest(output int id);
        bit found;
        found = 0;
        id = 0;
        for (int i = 0; i < n_procs; i++)
            if (st_tab[i] != psrp_pkg::ST_DONE && (!found || arr_tab[i] < arr_tab[id]))
            begin
                id = i;
                found = 1;
            end
        return found;
    endfunction

    function automatic bit find_best_prio(output int id);
        bit found;
        found = 0;
        id = 0;
        for (int i = 0; i < n_procs; i++)
            if (st_tab[i] == psrp_pkg::ST_READY && (!found || pri_tab[i] < pri_tab[id]))
            begin
                id = i;
                found = 1;
            end
        return found;
    endfunction

    function automatic sched_res_t serve_request(logic rq, logic [15:0] a,
                                                 logic [15:0] d, logic [7:0] p);
        sched_res_t r;
        int id;
        bit rr;
        logic [15:0] len;
        logic [23:0] start;
        r = '0;
        rr = (cfg_mode == psrp_pkg::MODE_RR);
        if (rq == psrp_pkg::REQ_ADD)
        begin
            if (n_procs >= NPROC)
            begin
                r.kind = psrp_pkg::RK_REJECT;
                return r;
            end
            arr_tab[n_procs] = a;
            dur_tab[n_procs] = d;
            rem_tab[n_procs] = d;
            pri_tab[n_procs] = p;
            fst_tab[n_procs] = '0;
            st_tab[n_procs]  = psrp_pkg::ST_WAIT;
            r.kind = psrp_pkg::RK_ADDED;
            r.id = 7'(n_procs);
            n_procs++;
            return r;
        end
        mark_arrived(rr);
        if (rr)
        begin
            if (ring_cnt == 0)
            begin
                if (!find_earliest(id))
                begin
                    r.kind = psrp_pkg::RK_NONE;
                    return r;
                end
                now_t = {8'd0, arr_tab[id]};
                mark_arrived(1);
                if (ring_cnt == 0)
                begin
                    r.kind = psrp_pkg::RK_NONE;
                    return r;
                end
            end
            id = ring[ring_rd];
            ring_rd = (ring_rd + 1) % NRING;
            ring_cnt--;
            len = (cfg_slice == 0) ? 16'd1 : cfg_slice;
            if (rem_tab[id] < len)
                len = rem_tab[id];
        end
        else
        begin
            if (!find_best_prio(id))
            begin
                if (!find_earliest(id))
                begin
                    r.kind = psrp_pkg::RK_NONE;
                    return r;
                end
                now_t = {8'd0, arr_tab[id]};
            end
            len = rem_tab[id];
        end
        start = now_t;
        if (rem_tab[id] == dur_tab[id])
            fst_tab[id] = start;
        rem_tab[id] = rem_tab[id] - len;
        r.kind  = psrp_pkg::RK_SCHED;
        r.id    = 7'(id);
        r.start = start;
        r.len   = len;
        r.left  = rem_tab[id];
        if (rem_tab[id] == 0)
        begin
            st_tab[id] = psrp_pkg::ST_DONE;
            r.fin = 1'b1;
            r.wt  = fst_tab[id] - {8'd0, arr_tab[id]};
            r.ta  = start + {8'd0, len} - {8'd0, arr_tab[id]};
        end
        else if (rr && ring_cnt < NRING)
        begin
            ring[ring_wr] = 7'(id);
            ring_wr = (ring_wr + 1) % NRING;
            ring_cnt++;
        end
        now_t = start + {8'd0, len};
        return r;
    endfunction

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(logic rq, logic [15:0] a, logic [15:0] d, logic [7:0] p);
        bit done;
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid     <= 1'b1;
        req_type     <= rq;
        arrive_time  <= a;
        run_duration <= d;
        prio_level   <= p;
        done = 0;
        while (!done)
        begin
            @(posedge clk);
            if (in_ready)
            begin
                pending_res.push_back(serve_request(rq, a, d, p));
                done = 1;
            end
        end
        @(negedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_res.size() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] data);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == psrp_pkg::ADDR_MODE)
            cfg_mode = data[0];
        else if (addr == psrp_pkg::ADDR_SLICE)
            cfg_slice = data[15:0];
    endtask

    task automatic set_config(logic mode, logic [15:0] slice);
        drain_results();
        write_reg(psrp_pkg::ADDR_MODE, {31'd0, mode});
        write_reg(psrp_pkg::ADDR_SLICE, {16'd0, slice});
    endtask

    task automatic send_random();
        logic [15:0] a;
        logic [15:0] d;
        bit add;
        add = (n_procs < NPROC) ? ($urandom_range(99) < 30) : ($urandom_range(99) < 5);
        case ($urandom_range(3))
            0: a = 16'($urandom_range(65535));
            default: a = now_t[15:0] + 16'($urandom_range(40));
        endcase
        d = ($urandom_range(15) == 0) ? 16'($urandom_range(65535))
                                      : 16'($urandom_range(12));
        send_item(add ? psrp_pkg::REQ_ADD : psrp_pkg::REQ_SCHED, a, d,
                  8'($urandom_range(255)));
    endtask

    task automatic test_directed();
        send_item(psrp_pkg::REQ_SCHED, 16'd0, 16'd0, 8'd0);
        send_item(psrp_pkg::REQ_ADD, 16'd0, 16'd3, 8'd255);
        send_item(psrp_pkg::REQ_ADD, 16'd5, 16'd0, 8'd0);
        send_item(psrp_pkg::REQ_ADD, 16'd65535, 16'd1, 8'd7);
        send_item(psrp_pkg::REQ_ADD, 16'd1, 16'd4, 8'd7);
        send_item(psrp_pkg::REQ_ADD, 16'd2, 16'd65535, 8'd128);
        repeat (6) send_item(psrp_pkg::REQ_SCHED, 16'hFFFF, 16'hFFFF, 8'hFF);
        set_config(1'b1, 16'd2);
        repeat (5) send_item(psrp_pkg::REQ_SCHED, 16'd0, 16'd0, 8'd0);
    endtask

    task automatic test_random_phase(int n, int idle, int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
        repeat (n) send_random();
        send_idle_pct = 0;
        stall_pct     = 0;
    endtask

    task automatic test_backpressure();
        @(posedge clk);
        hold_req = 2000;
        @(negedge clk);
        repeat (30) send_random();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        req_type = psrp_pkg::REQ_ADD;
        arrive_time = '0;
        run_duration = '0;
        prio_level = '0;
        out_ready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        n_procs = 0;
        ring_rd = 0;
        ring_wr = 0;
        ring_cnt = 0;
        now_t = '0;
        cfg_mode = psrp_pkg::MODE_RR;
        cfg_slice = psrp_pkg::SLICE_RST;
        n_err = 0;
        n_cycles = 0;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_req = 0;
        hold_cnt = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        set_config(psrp_pkg::MODE_RR, 16'd1);
        test_random_phase(150, 0, 0);
        set_config(1'b1, 16'd65535);
        test_random_phase(150, 45, 0);
        set_config(psrp_pkg::MODE_RR, 16'd65535);
        test_random_phase(150, 0, 45);
        set_config(psrp_pkg::MODE_RR, 16'd0);
        test_random_phase(150, 26, 26);
        set_config(1'b1, 16'd3);
        test_backpressure();
        drain_results();
        if (n_err == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
